// ===== sv/pfl_pkg.sv =====
package pfl_pkg;

	typedef logic [31:0] word_t;
	typedef logic [1:0]  status_t;

	// Result status codes.
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_NOMEM = 2'd1;
	localparam status_t ST_FAULT = 2'd2;

	// Request modes.
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	// Allocations are rounded up to a multiple of this grain (a power of two).
	localparam int GRAIN_LOG2 = 4;

	// Tag and link encodings held in the word store.
	localparam word_t TAG_FREE = 32'h8000_0000;
	localparam word_t NO_PTR   = 32'hFFFF_FFFF;

endpackage

// ===== sv/pfl_if.sv =====
// Request channel: one word per allocate or free request.
interface pfl_req_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [15:0] request_size;
	logic [15:0] block_address;
	logic        merge_left;

	modport source(output valid, mode, request_size, block_address, merge_left,
		input ready);
	modport sink(input valid, mode, request_size, block_address, merge_left,
		output ready);
endinterface

// Response channel: one word per request.
interface pfl_rsp_if;
	logic                 valid;
	logic                 ready;
	logic [15:0]          result_address;
	logic [16:0]          granted_size;
	pfl_pkg::status_t     status;

	modport source(output valid, result_address, granted_size, status, input ready);
	modport sink(input valid, result_address, granted_size, status, output ready);
endinterface

// ===== sv/pfl_store.sv =====
// Single-port word store with registered read data and a clearing sweep after reset.
module pfl_store #(
	parameter int STORE_WORDS = 65536,
	parameter int AW          = 18
) (
	input  logic           clk,
	input  logic           arst_n,
	output logic           busy,
	input  logic           re,
	input  logic           we,
	input  logic [AW-1:0]  addr,
	input  pfl_pkg::word_t wdata,
	output pfl_pkg::word_t rdata
);

	localparam int IW = $clog2(STORE_WORDS);
	localparam int CW = $clog2(STORE_WORDS + 1);

	pfl_pkg::word_t mem [STORE_WORDS];
	pfl_pkg::word_t rdata_q;
	logic [CW-1:0]  clr_q;
	logic           in_range;

	// Accesses beyond the store read as zero and do not write.
	assign in_range = addr < AW'(STORE_WORDS);
	assign busy     = clr_q < CW'(STORE_WORDS);
	assign rdata    = rdata_q;

	// Clearing sweep pointer, one word per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (busy) begin
			clr_q <= clr_q + CW'(1);
		end
	end

	// Write port.
	always_ff @(posedge clk) begin
		if (busy) begin
			mem[clr_q[IW-1:0]] <= '0;
		end else if (we && in_range) begin
			mem[addr[IW-1:0]] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= in_range ? mem[addr[IW-1:0]] : '0;
		end
	end

endmodule

// ===== sv/pfl_core.sv =====
// Allocation sequencer: list heads, chunk walking and all store traffic.
module pfl_core #(
	parameter int STORE_WORDS    = 65536,
	parameter int NUM_LISTS      = 16,
	parameter int MIN_FREE_CHUNK = 16,
	parameter int AW             = 18
) (
	input  logic             clk,
	input  logic             arst_n,
	pfl_req_if.sink          req,
	input  logic             mem_ready,
	output logic             mem_re,
	output logic             mem_we,
	output logic [AW-1:0]    mem_addr,
	output pfl_pkg::word_t   mem_wdata,
	input  pfl_pkg::word_t   mem_rdata,
	output logic             res_valid,
	input  logic             res_ready,
	output logic [15:0]      res_addr,
	output logic [16:0]      res_size,
	output pfl_pkg::status_t res_status
);

	localparam int IW = $clog2(STORE_WORDS);
	localparam int LW = $clog2(NUM_LISTS);
	localparam int MW = $clog2(AW);
	localparam int SW = MW + 1;

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_DEC    = 5'd1;
	localparam logic [4:0] S_AGET   = 5'd2;
	localparam logic [4:0] S_RM_RD1 = 5'd3;
	localparam logic [4:0] S_RM_RD2 = 5'd4;
	localparam logic [4:0] S_RM_W1  = 5'd5;
	localparam logic [4:0] S_RM_W2  = 5'd6;
	localparam logic [4:0] S_RM_W3  = 5'd7;
	localparam logic [4:0] S_RM_W4  = 5'd8;
	localparam logic [4:0] S_AL_REM = 5'd9;
	localparam logic [4:0] S_AL_T1  = 5'd10;
	localparam logic [4:0] S_AL_T2  = 5'd11;
	localparam logic [4:0] S_FR_CHK = 5'd12;
	localparam logic [4:0] S_FR_TST = 5'd13;
	localparam logic [4:0] S_FL_CHK = 5'd14;
	localparam logic [4:0] S_FL_TST = 5'd15;
	localparam logic [4:0] S_SP_CHK = 5'd16;
	localparam logic [4:0] S_IN_W1  = 5'd17;
	localparam logic [4:0] S_IN_W2  = 5'd18;
	localparam logic [4:0] S_IN_W3  = 5'd19;
	localparam logic [4:0] S_IN_W4  = 5'd20;
	localparam logic [4:0] S_IN_W5  = 5'd21;
	localparam logic [4:0] S_DONE   = 5'd22;

	// Where an unlink returns to.
	localparam logic [1:0] RET_RIGHT = 2'd0;
	localparam logic [1:0] RET_LEFT  = 2'd1;
	localparam logic [1:0] RET_ALLOC = 2'd2;

	function automatic logic [MW-1:0] msb_of(input logic [AW-1:0] v);
		logic [MW-1:0] r;
		r = '0;
		for (int i = 0; i < AW; i++) begin
			if (v[i]) begin
				r = MW'(i);
			end
		end
		return r;
	endfunction

	logic [4:0]       state_q;
	logic [1:0]       ret_q;
	logic [NUM_LISTS-1:0] hv_q;
	logic [IW-1:0]    head_q [NUM_LISTS];

	logic             mode_q;
	logic [15:0]      req_q;
	logic [15:0]      addr_q;
	logic             left_q;
	logic [AW-1:0]    fa_ref_q;
	logic [AW-1:0]    fa_n_q;
	logic             fa_left_q;
	logic [AW-1:0]    rm_ref_q;
	logic [AW-1:0]    al_ref_q;
	logic [AW-1:0]    al_size_q;
	logic [LW-1:0]    lst_q;
	pfl_pkg::word_t   nxt_q;
	pfl_pkg::word_t   prv_q;
	logic [15:0]      res_addr_q;
	logic [16:0]      res_size_q;
	pfl_pkg::status_t res_st_q;

	logic             accept;
	logic [AW-1:0]    s_lst;
	logic             hd_v;
	logic [IW-1:0]    hd_a;
	pfl_pkg::word_t   hd_w;
	logic [AW-1:0]    p_right;
	logic [30:0]      tag_sz31;
	logic             tag_shape;
	logic             r_ok;
	logic             l_ok;
	logic [AW-1:0]    tag_sz;
	logic [LW-1:0]    tag_lst;
	logic             nxt_ok;
	logic             prv_ok;
	logic [AW-1:0]    sz_w;
	logic [SW-1:0]    start_w;
	logic             fnd;
	logic [LW-1:0]    fnd_idx;
	logic [AW-1:0]    rem_w;
	logic             range_bad;
	logic [MW-1:0]    n_msb;
	logic [LW-1:0]    sp_lst;
	logic             n_big;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE) && mem_ready;

	// Head of the current list, as a link word.
	assign s_lst = AW'(1) << lst_q;
	assign hd_v  = hv_q[lst_q];
	assign hd_a  = head_q[lst_q];
	assign hd_w  = hd_v ? 32'(hd_a) : pfl_pkg::NO_PTR;

	// Neighbour tag checks on the word just read.
	assign p_right   = fa_ref_q + fa_n_q;
	assign tag_sz31  = mem_rdata[30:0];
	assign tag_shape = (tag_sz31 >= 31'd4) && ((tag_sz31 & (tag_sz31 - 31'd1)) == '0)
		&& (tag_sz31 < (31'(1) << NUM_LISTS));
	assign r_ok      = mem_rdata[31] && tag_shape
		&& ({1'b0, tag_sz31} + 32'(p_right) <= 32'(STORE_WORDS));
	assign l_ok      = mem_rdata[31] && tag_shape && ({1'b0, tag_sz31} <= 32'(fa_ref_q));
	assign tag_sz    = AW'(tag_sz31);
	assign tag_lst   = LW'(msb_of(tag_sz));

	assign nxt_ok = nxt_q < 32'(STORE_WORDS);
	assign prv_ok = prv_q < 32'(STORE_WORDS);

	// Rounded allocation size and the first list large enough that holds a chunk.
	assign sz_w    = (((AW'(req_q) - AW'(1)) >> pfl_pkg::GRAIN_LOG2) + AW'(1))
		<< pfl_pkg::GRAIN_LOG2;
	assign start_w = {1'b0, msb_of(sz_w - AW'(1))} + SW'(1);

	always_comb begin
		fnd     = 1'b0;
		fnd_idx = '0;
		for (int i = 0; i < NUM_LISTS; i++) begin
			if (!fnd && hv_q[i] && (SW'(i) >= start_w)) begin
				fnd     = 1'b1;
				fnd_idx = LW'(i);
			end
		end
	end

	assign rem_w     = s_lst - al_size_q;
	assign range_bad = (AW'(addr_q) + AW'(req_q)) > AW'(STORE_WORDS);

	// Largest chunk that the remaining area holds, capped at the top list.
	assign n_msb  = msb_of(fa_n_q);
	assign sp_lst = (n_msb > MW'(NUM_LISTS - 1)) ? LW'(NUM_LISTS - 1) : LW'(n_msb);
	assign n_big  = fa_n_q >= AW'(MIN_FREE_CHUNK);

	// Store port: one read or one write per cycle.
	always_comb begin
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = '0;
		mem_wdata = '0;
		case (state_q)
			S_RM_RD1: begin
				mem_re   = 1'b1;
				mem_addr = rm_ref_q + AW'(1);
			end
			S_RM_RD2: begin
				mem_re   = 1'b1;
				mem_addr = rm_ref_q + AW'(2);
			end
			S_RM_W1: begin
				mem_we    = 1'b1;
				mem_addr  = rm_ref_q;
				mem_wdata = 32'(s_lst);
			end
			S_RM_W2: begin
				mem_we    = 1'b1;
				mem_addr  = rm_ref_q + s_lst - AW'(1);
				mem_wdata = 32'(s_lst);
			end
			S_RM_W3: begin
				mem_we    = nxt_ok;
				mem_addr  = AW'(nxt_q) + AW'(2);
				mem_wdata = prv_q;
			end
			S_RM_W4: begin
				mem_we    = prv_ok;
				mem_addr  = AW'(prv_q) + AW'(1);
				mem_wdata = nxt_q;
			end
			S_AL_T1: begin
				mem_we    = 1'b1;
				mem_addr  = al_ref_q;
				mem_wdata = 32'(al_size_q);
			end
			S_AL_T2: begin
				mem_we    = 1'b1;
				mem_addr  = al_ref_q + al_size_q - AW'(1);
				mem_wdata = 32'(al_size_q);
			end
			S_FR_CHK: begin
				mem_re   = p_right < AW'(STORE_WORDS);
				mem_addr = p_right;
			end
			S_FL_CHK: begin
				mem_re   = 1'b1;
				mem_addr = fa_ref_q - AW'(1);
			end
			S_IN_W1: begin
				mem_we    = 1'b1;
				mem_addr  = fa_ref_q;
				mem_wdata = pfl_pkg::TAG_FREE | 32'(s_lst);
			end
			S_IN_W2: begin
				mem_we    = 1'b1;
				mem_addr  = fa_ref_q + AW'(1);
				mem_wdata = hd_w;
			end
			S_IN_W3: begin
				mem_we    = hd_v;
				mem_addr  = AW'(hd_a) + AW'(2);
				mem_wdata = 32'(fa_ref_q);
			end
			S_IN_W4: begin
				mem_we    = 1'b1;
				mem_addr  = fa_ref_q + AW'(2);
				mem_wdata = pfl_pkg::NO_PTR;
			end
			S_IN_W5: begin
				mem_we    = 1'b1;
				mem_addr  = fa_ref_q + s_lst - AW'(1);
				mem_wdata = pfl_pkg::TAG_FREE | 32'(s_lst);
			end
			default: begin
			end
		endcase
	end

	// Sequencer state, unlink return point and head valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= RET_RIGHT;
			hv_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					if (req_q == '0) begin
						state_q <= S_DONE;
					end else if (mode_q == pfl_pkg::MODE_FREE) begin
						state_q <= range_bad ? S_DONE : S_FR_CHK;
					end else begin
						state_q <= fnd ? S_AGET : S_DONE;
					end
				end
				S_AGET: begin
					ret_q   <= RET_ALLOC;
					state_q <= S_RM_RD1;
				end
				S_RM_RD1: state_q <= S_RM_RD2;
				S_RM_RD2: state_q <= S_RM_W1;
				S_RM_W1:  state_q <= S_RM_W2;
				S_RM_W2: begin
					if (hd_v && (hd_a == IW'(rm_ref_q))) begin
						hv_q[lst_q] <= nxt_ok;
					end
					state_q <= S_RM_W3;
				end
				S_RM_W3: state_q <= S_RM_W4;
				S_RM_W4: begin
					case (ret_q)
						RET_RIGHT: state_q <= S_FR_CHK;
						RET_LEFT:  state_q <= S_FL_CHK;
						default:   state_q <= S_AL_REM;
					endcase
				end
				S_AL_REM: begin
					state_q <= (rem_w >= AW'(MIN_FREE_CHUNK)) ? S_FR_CHK : S_AL_T1;
				end
				S_AL_T1: state_q <= S_AL_T2;
				S_AL_T2: state_q <= S_DONE;
				S_FR_CHK: begin
					state_q <= (p_right < AW'(STORE_WORDS)) ? S_FR_TST : S_FL_CHK;
				end
				S_FR_TST: begin
					if (r_ok) begin
						ret_q   <= RET_RIGHT;
						state_q <= S_RM_RD1;
					end else begin
						state_q <= S_FL_CHK;
					end
				end
				S_FL_CHK: begin
					state_q <= (fa_left_q && (fa_ref_q != '0)) ? S_FL_TST : S_SP_CHK;
				end
				S_FL_TST: begin
					if (l_ok) begin
						ret_q   <= RET_LEFT;
						state_q <= S_RM_RD1;
					end else begin
						state_q <= S_SP_CHK;
					end
				end
				S_SP_CHK: begin
					if (n_big) begin
						state_q <= S_IN_W1;
					end else if (mode_q == pfl_pkg::MODE_ALLOC) begin
						state_q <= S_AL_T1;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_IN_W1: state_q <= S_IN_W2;
				S_IN_W2: state_q <= S_IN_W3;
				S_IN_W3: begin
					hv_q[lst_q] <= 1'b1;
					state_q     <= S_IN_W4;
				end
				S_IN_W4: state_q <= S_IN_W5;
				S_IN_W5: state_q <= S_SP_CHK;
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers of the current request.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					mode_q <= req.mode;
					req_q  <= req.request_size;
					addr_q <= req.block_address;
					left_q <= req.merge_left;
				end
			end
			S_DEC: begin
				res_addr_q <= '0;
				res_size_q <= '0;
				res_st_q   <= pfl_pkg::ST_OK;
				fa_ref_q   <= AW'(addr_q);
				fa_n_q     <= AW'(req_q);
				fa_left_q  <= left_q;
				al_size_q  <= sz_w;
				lst_q      <= fnd_idx;
				if (req_q == '0) begin
					res_st_q <= pfl_pkg::ST_FAULT;
				end else if (mode_q == pfl_pkg::MODE_FREE) begin
					if (range_bad) begin
						res_st_q <= pfl_pkg::ST_FAULT;
					end
				end else if (!fnd) begin
					res_st_q <= pfl_pkg::ST_NOMEM;
				end
			end
			S_AGET: begin
				al_ref_q <= AW'(hd_a);
				rm_ref_q <= AW'(hd_a);
			end
			S_RM_RD2: nxt_q <= mem_rdata;
			S_RM_W1:  prv_q <= mem_rdata;
			S_RM_W2: begin
				if (hd_v && (hd_a == IW'(rm_ref_q)) && nxt_ok) begin
					head_q[lst_q] <= IW'(nxt_q);
				end
			end
			S_AL_REM: begin
				if (rem_w >= AW'(MIN_FREE_CHUNK)) begin
					fa_ref_q  <= al_ref_q + al_size_q;
					fa_n_q    <= rem_w;
					fa_left_q <= 1'b0;
				end else begin
					al_size_q <= s_lst;
				end
			end
			S_AL_T2: begin
				res_addr_q <= 16'(al_ref_q);
				res_size_q <= 17'(al_size_q);
			end
			S_FR_TST: begin
				if (r_ok) begin
					fa_n_q   <= fa_n_q + tag_sz;
					rm_ref_q <= p_right;
					lst_q    <= tag_lst;
				end
			end
			S_FL_TST: begin
				if (l_ok) begin
					fa_ref_q <= fa_ref_q - tag_sz;
					fa_n_q   <= fa_n_q + tag_sz;
					rm_ref_q <= fa_ref_q - tag_sz;
					lst_q    <= tag_lst;
				end
			end
			S_SP_CHK: begin
				if (n_big) begin
					lst_q <= sp_lst;
				end
			end
			S_IN_W3: head_q[lst_q] <= IW'(fa_ref_q);
			S_IN_W5: begin
				fa_ref_q <= fa_ref_q + s_lst;
				fa_n_q   <= fa_n_q - s_lst;
			end
			default: begin
			end
		endcase
	end

	assign res_valid  = state_q == S_DONE;
	assign res_addr   = res_addr_q;
	assign res_size   = res_size_q;
	assign res_status = res_st_q;

endmodule

// ===== sv/power_of_two_free_list_allocator_unit.sv =====
// Channel  Dir  Word contents
// req      in   mode, request_size, block_address, merge_left
// rsp      out  result_address, granted_size, status
//
// After reset the word store is swept clear, one word a cycle, with req.ready low.
// A request is taken in the idle state, decoded, and hands over its result from the done state.
// An allocation picks the head, unlinks it, sizes the remainder and writes its tags. Each
// neighbour probe reads a tag and tests it, unless there is nothing to probe; each unlinked
// neighbour is read and relinked, each chunk put on a list has its tags and links written,
// and the split ends with a check. The single port of the word store takes these one at a time.
// The result waits in an output register; a new request is taken while it waits.
module power_of_two_free_list_allocator_unit #(
	parameter int STORE_WORDS    = 65536,
	parameter int NUM_LISTS      = 16,
	parameter int MIN_FREE_CHUNK = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	pfl_req_if.sink    req,
	pfl_rsp_if.source  rsp
);

	localparam int IW = $clog2(STORE_WORDS);
	localparam int AW = (IW + 2 > 18) ? IW + 2 : 18;

	logic             mem_busy;
	logic             mem_re;
	logic             mem_we;
	logic [AW-1:0]    mem_addr;
	pfl_pkg::word_t   mem_wdata;
	pfl_pkg::word_t   mem_rdata;
	logic             res_valid;
	logic             res_ready;
	logic [15:0]      res_addr;
	logic [16:0]      res_size;
	pfl_pkg::status_t res_status;
	logic             out_v_q;
	logic [15:0]      out_addr_q;
	logic [16:0]      out_size_q;
	pfl_pkg::status_t out_st_q;

	pfl_store #(
		.STORE_WORDS(STORE_WORDS),
		.AW         (AW)
	) u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.busy  (mem_busy),
		.re    (mem_re),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	pfl_core #(
		.STORE_WORDS   (STORE_WORDS),
		.NUM_LISTS     (NUM_LISTS),
		.MIN_FREE_CHUNK(MIN_FREE_CHUNK),
		.AW            (AW)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.mem_ready (!mem_busy),
		.mem_re    (mem_re),
		.mem_we    (mem_we),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_addr  (res_addr),
		.res_size  (res_size),
		.res_status(res_status)
	);

	// Output register: loads when empty or when its word is taken.
	assign res_ready = !out_v_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (res_ready) begin
			out_v_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_addr_q <= res_addr;
			out_size_q <= res_size;
			out_st_q   <= res_status;
		end
	end

	assign rsp.valid          = out_v_q;
	assign rsp.result_address = out_addr_q;
	assign rsp.granted_size   = out_size_q;
	assign rsp.status         = out_st_q;

endmodule

// ===== sv/pfl_chk.sv =====
// Port-level checks on the allocator.
module pfl_chk (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [15:0]      result_address,
	input logic [16:0]      granted_size,
	input pfl_pkg::status_t status
);

	// A stalled response word holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_address)
			&& $stable(granted_size) && $stable(status))
		else $error("response word changed while stalled");

	// A failed request grants nothing.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != pfl_pkg::ST_OK) |-> (result_address == '0)
			&& (granted_size == '0))
		else $error("failed request carries an address or size");

	// Grants are whole grains, and a full-range grant is exactly the largest size.
	a_grain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (granted_size[3:0] == '0)
			&& (!granted_size[16] || (granted_size[15:0] == '0)))
		else $error("granted size not a whole grain");

	// The sequencer is busy in the cycle after it takes a request.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while the previous one is in progress");

endmodule

bind power_of_two_free_list_allocator_unit pfl_chk u_pfl_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (req.valid),
	.in_ready      (req.ready),
	.out_valid     (rsp.valid),
	.out_ready     (rsp.ready),
	.result_address(rsp.result_address),
	.granted_size  (rsp.granted_size),
	.status        (rsp.status)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

	localparam int STORE_WORDS = 65536;
	localparam int NUM_LISTS = 16;
	localparam int MIN_FREE_CHUNK = 16;
	localparam int GRAIN = 16;
	localparam int LIMIT_CYCLES = 4000000;

	typedef struct packed {
		logic        mode;
		logic [15:0] request_size;
		logic [15:0] block_address;
		logic        merge_left;
	} alloc_req_t;

	typedef struct packed {
		logic [15:0]      result_address;
		logic [16:0]      granted_size;
		pfl_pkg::status_t status;
	} alloc_rsp_t;

	logic clk;
	logic arst_n;

	pfl_req_if req ();
	pfl_rsp_if rsp ();

	power_of_two_free_list_allocator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	// Clock; reset is driven by the stimulus.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Shadow copy of the allocator state.
	pfl_pkg::word_t shadow_store [STORE_WORDS];
	logic [31:0]    shadow_heads [NUM_LISTS];

	alloc_req_t  pending_reqs[$];
	alloc_rsp_t  expected_rsps[$];
	logic [15:0] live_addr[$];
	logic [16:0] live_size[$];

	int  failures;
	int  cycle_count;
	bit  calm_phase;
	bit  hold_sender;
	bit  stim_done;

	function automatic pfl_pkg::word_t store_read(logic [31:0] a);
		return a < STORE_WORDS ? shadow_store[a] : 32'd0;
	endfunction

	function automatic void store_write(logic [31:0] a, pfl_pkg::word_t v);
		if (a < STORE_WORDS)
			shadow_store[a] = v;
	endfunction

	function automatic int msb_count(logic [31:0] x);
		int n;
		n = 0;
		while (x != 0) begin
			n++;
			x = x >> 1;
		end
		return n;
	endfunction

	function automatic bit size_valid(logic [31:0] s);
		if (s < 4 || (s & (s - 1)) != 0)
			return 0;
		return msb_count(s) - 1 < NUM_LISTS;
	endfunction

	function automatic void unlink_chunk(logic [31:0] ref_a, int lst);
		logic [31:0] s;
		logic [31:0] nxt;
		logic [31:0] prv;
		s = 32'd1 << lst;
		nxt = store_read(ref_a + 1);
		prv = store_read(ref_a + 2);
		store_write(ref_a, s);
		store_write(ref_a + s - 1, s);
		if (shadow_heads[lst] == ref_a)
			shadow_heads[lst] = nxt < STORE_WORDS ? nxt : pfl_pkg::NO_PTR;
		if (nxt < STORE_WORDS)
			store_write(nxt + 2, prv);
		if (prv < STORE_WORDS)
			store_write(prv + 1, nxt);
	endfunction

	function automatic void link_chunk(logic [31:0] ref_a, int lst);
		logic [31:0] s;
		logic [31:0] h;
		s = 32'd1 << lst;
		h = shadow_heads[lst];
		store_write(ref_a, pfl_pkg::TAG_FREE | s);
		store_write(ref_a + 1, h);
		if (h < STORE_WORDS)
			store_write(h + 2, ref_a);
		shadow_heads[lst] = ref_a;
		store_write(ref_a + 2, pfl_pkg::NO_PTR);
		store_write(ref_a + s - 1, pfl_pkg::TAG_FREE | s);
	endfunction

	function automatic void release_area(logic [31:0] ref_a, logic [31:0] n, bit left);
		logic [31:0] p;
		logic [31:0] t;
		logic [31:0] s;
		int lst;
		// Absorb free chunks to the right.
		while (ref_a + n < STORE_WORDS) begin
			p = ref_a + n;
			t = store_read(p);
			s = t & 32'h7FFF_FFFF;
			if ((t & pfl_pkg::TAG_FREE) == 0 || !size_valid(s) || s > STORE_WORDS - p)
				break;
			n += s;
			unlink_chunk(p, msb_count(s) - 1);
		end
		// Optionally absorb free chunks to the left.
		while (left && ref_a > 0) begin
			t = store_read(ref_a - 1);
			s = t & 32'h7FFF_FFFF;
			if ((t & pfl_pkg::TAG_FREE) == 0 || !size_valid(s) || s > ref_a)
				break;
			ref_a -= s;
			n += s;
			unlink_chunk(ref_a, msb_count(s) - 1);
		end
		// Cut the area into power-of-two chunks, largest first, capped at the top list.
		while (n >= MIN_FREE_CHUNK) begin
			lst = msb_count(n) - 1;
			if (lst > NUM_LISTS - 1)
				lst = NUM_LISTS - 1;
			link_chunk(ref_a, lst);
			ref_a += 32'd1 << lst;
			n -= 32'd1 << lst;
		end
	endfunction

	function automatic alloc_rsp_t predict_allocator(alloc_req_t r);
		alloc_rsp_t  o;
		logic [31:0] size;
		logic [31:0] ref_a;
		logic [31:0] rem;
		bit found;
		o = '0;
		found = 0;
		if (r.request_size == 0) begin
			o.status = pfl_pkg::ST_FAULT;
		end else if (r.mode == pfl_pkg::MODE_FREE) begin
			if (32'(r.block_address) + 32'(r.request_size) > STORE_WORDS)
				o.status = pfl_pkg::ST_FAULT;
			else
				release_area(32'(r.block_address), 32'(r.request_size), r.merge_left);
		end else begin
			size = ((32'(r.request_size) - 1) / GRAIN + 1) * GRAIN;
			for (int i = msb_count(size - 1); i < NUM_LISTS && !found; i++) begin
				ref_a = shadow_heads[i];
				if (ref_a < STORE_WORDS) begin
					unlink_chunk(ref_a, i);
					rem = (32'd1 << i) - size;
					if (rem >= MIN_FREE_CHUNK)
						release_area(ref_a + size, rem, 0);
					else
						size = 32'd1 << i;
					store_write(ref_a, size);
					store_write(ref_a + size - 1, size);
					o.result_address = ref_a[15:0];
					o.granted_size = size[16:0];
					found = 1;
				end
			end
			if (!found)
				o.status = pfl_pkg::ST_NOMEM;
		end
		return o;
	endfunction

	// Driver: presents queued words, idling at random outside the calm phase.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.mode <= pfl_pkg::MODE_ALLOC;
			req.request_size <= '0;
			req.block_address <= '0;
			req.merge_left <= 1'b0;
		end else begin
			alloc_rsp_t exp_rsp;
			alloc_req_t nxt_req;
			if (req.valid && req.ready) begin
				exp_rsp = predict_allocator({req.mode, req.request_size,
					req.block_address, req.merge_left});
				expected_rsps.push_back(exp_rsp);
				if (exp_rsp.status == pfl_pkg::ST_OK && req.mode == pfl_pkg::MODE_ALLOC) begin
					live_addr.push_back(exp_rsp.result_address);
					live_size.push_back(exp_rsp.granted_size);
				end
			end
			if ((!req.valid || req.ready) && pending_reqs.size() > 0 && !hold_sender
					&& (calm_phase || $urandom_range(99) >= 26)) begin
				nxt_req = pending_reqs.pop_front();
				req.valid <= 1'b1;
				req.mode <= nxt_req.mode;
				req.request_size <= nxt_req.request_size;
				req.block_address <= nxt_req.block_address;
				req.merge_left <= nxt_req.merge_left;
			end else if (req.ready) begin
				req.valid <= 1'b0;
			end
		end
	end

	// Monitor: random back-pressure and comparison with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			cycle_count <= 0;
		end else begin
			alloc_rsp_t exp_rsp;
			cycle_count <= cycle_count + 1;
			rsp.ready <= calm_phase || $urandom_range(99) >= 26;
			if (rsp.valid && rsp.ready) begin
				if (expected_rsps.size() == 0) begin
					$display("%0t: unexpected result addr=%h size=%h status=%0d", $time,
						rsp.result_address, rsp.granted_size, rsp.status);
					failures++;
				end else begin
					exp_rsp = expected_rsps.pop_front();
					if (exp_rsp.result_address !== rsp.result_address) begin
						$display("%0t: result_address expected %h actual %h", $time,
							exp_rsp.result_address, rsp.result_address);
						failures++;
					end
					if (exp_rsp.granted_size !== rsp.granted_size) begin
						$display("%0t: granted_size expected %h actual %h", $time,
							exp_rsp.granted_size, rsp.granted_size);
						failures++;
					end
					if (exp_rsp.status !== rsp.status) begin
						$display("%0t: status expected %0d actual %0d", $time,
							exp_rsp.status, rsp.status);
						failures++;
					end
				end
			end
		end
	end

	function automatic alloc_req_t make_req(logic m, logic [15:0] sz, logic [15:0] a, logic l);
		alloc_req_t r;
		r.mode = m;
		r.request_size = sz;
		r.block_address = a;
		r.merge_left = l;
		return r;
	endfunction

	// Random word: mostly frees of earlier grants or fresh areas, and allocations.
	task automatic queue_random_word();
		int sel;
		int idx;
		logic [15:0] a;
		logic [15:0] sz;
		sel = $urandom_range(99);
		if (sel < 45) begin
			sz = (sel < 40) ? 16'($urandom_range(1, 300)) : 16'($urandom_range(1, 4096));
			pending_reqs.push_back(make_req(pfl_pkg::MODE_ALLOC, sz, 16'($urandom),
				1'($urandom)));
		end else if (sel < 80 && live_addr.size() > 0) begin
			idx = $urandom_range(live_addr.size() - 1);
			a = live_addr[idx];
			sz = live_size[idx][15:0];
			if (live_size[idx] > 17'hFFFF)
				sz = 16'hFFFF;
			live_addr.delete(idx);
			live_size.delete(idx);
			pending_reqs.push_back(make_req(pfl_pkg::MODE_FREE, sz, a, 1'($urandom)));
		end else if (sel < 92) begin
			a = 16'($urandom_range(0, 4095)) << 4;
			sz = 16'($urandom_range(1, 64)) << 4;
			pending_reqs.push_back(make_req(pfl_pkg::MODE_FREE, sz, a, 1'($urandom)));
		end else begin
			pending_reqs.push_back(make_req(1'($urandom), 16'($urandom),
				16'($urandom), 1'($urandom)));
		end
	endtask

	// Looks at the queues away from the rising edge, once the driver has settled.
	task automatic wait_drained();
		@(negedge clk);
		while (pending_reqs.size() > 0 || req.valid || expected_rsps.size() > 0)
			@(negedge clk);
	endtask

	// Stimulus.
	initial begin
		failures = 0;
		calm_phase = 0;
		hold_sender = 0;
		stim_done = 0;
		for (int i = 0; i < STORE_WORDS; i++)
			shadow_store[i] = '0;
		for (int i = 0; i < NUM_LISTS; i++)
			shadow_heads[i] = pfl_pkg::NO_PTR;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n = 1'b1;

		// Directed words: faults, empty store, extremes and merges.
		pending_reqs.push_back(make_req(pfl_pkg::MODE_ALLOC, 16'd0, 16'd0, 1'b0));
		pending_reqs.push_back(make_req(pfl_pkg::MODE_FREE, 16'd0, 16'h1234, 1'b1));
		pending_reqs.push_back(make_req(pfl_pkg::MODE_ALLOC, 16'd1, 16'hFFFF, 1'b1));
		pending_reqs.push_back(make_req(pfl_pkg::MODE_FREE, 16'd2, 16'hFFFF, 1'b0));
		pending_reqs.push_back(make_req(pfl_pkg::MODE_FREE, 16'hFFFF, 16'd0, 1'b0));
		pending_reqs.push_back(make_req(pfl_pkg::MODE_FREE, 16'd1, 16'hFFFF, 1'b1));
		pending_reqs.push_back(make_req(pfl_pkg::MODE_ALLOC, 16'hFFFF, 16'd0, 1'b0));
		pending_reqs.push_back(make_req(pfl_pkg::MODE_ALLOC, 16'd32768, 16'd0, 1'b0));
		pending_reqs.push_back(make_req(pfl_pkg::MODE_ALLOC, 16'd17, 16'd0, 1'b0));
		pending_reqs.push_back(make_req(pfl_pkg::MODE_ALLOC, 16'd48, 16'd0, 1'b0));
		pending_reqs.push_back(make_req(pfl_pkg::MODE_ALLOC, 16'd1000, 16'd0, 1'b0));
		pending_reqs.push_back(make_req(pfl_pkg::MODE_FREE, 16'd7, 16'd3, 1'b0));
		pending_reqs.push_back(make_req(pfl_pkg::MODE_FREE, 16'd100, 16'd100, 1'b1));
		pending_reqs.push_back(make_req(pfl_pkg::MODE_FREE, 16'd16, 16'd84, 1'b1));
		pending_reqs.push_back(make_req(pfl_pkg::MODE_FREE, 16'hFFFF, 16'd1, 1'b1));
		pending_reqs.push_back(make_req(pfl_pkg::MODE_FREE, 16'd1, 16'd0, 1'b1));
		pending_reqs.push_back(make_req(pfl_pkg::MODE_ALLOC, 16'd16, 16'd0, 1'b0));
		pending_reqs.push_back(make_req(pfl_pkg::MODE_ALLOC, 16'd32768, 16'd0, 1'b0));
		pending_reqs.push_back(make_req(pfl_pkg::MODE_ALLOC, 16'd65535, 16'd0, 1'b0));
		pending_reqs.push_back(make_req(pfl_pkg::MODE_ALLOC, 16'd5, 16'd0, 1'b0));
		wait_drained();

		// Pause the sender while random words are queued, then release it.
		hold_sender = 1;
		for (int i = 0; i < 30; i++)
			queue_random_word();
		hold_sender = 0;
		wait_drained();

		// Random words, with a calm stretch in the middle.
		for (int i = 0; i < 1500; i++) begin
			while (pending_reqs.size() > 4)
				@(posedge clk);
			calm_phase = (i >= 600 && i < 800);
			queue_random_word();
		end
		wait_drained();
		calm_phase = 0;
		repeat (200) @(posedge clk);
		stim_done = 1;
	end

	// End of run.
	always @(posedge clk) begin
		if (stim_done) begin
			if (failures == 0 && expected_rsps.size() == 0)
				$display("[ OK ] regression clean");
			else
				$display("[FAIL] regression broken");
			$finish;
		end else if (cycle_count > LIMIT_CYCLES) begin
			$display("%0t: timeout", $time);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

endmodule

// ===== sim.f =====
sv/pfl_pkg.sv
sv/pfl_if.sv
sv/pfl_store.sv
sv/pfl_core.sv
sv/power_of_two_free_list_allocator_unit.sv
sv/pfl_chk.sv
tb/sv/tb_top.sv
